### hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define A2HID_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the trigger holds, the consequence must hold at the next clock edge.
`define A2HID_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

### hw/rtl/a2hid_pkg.sv
// Package for the ASCII to HID keyboard report packer.
// Holds the sizes, usage codes, shared types and the character classifier; no dependencies.
`default_nettype none

package a2hid_pkg;

    localparam int KEY_SLOTS    = 6;
    localparam int REPORT_SLOTS = 6;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MOD_NONE   = 2'd0;
    localparam logic [1:0] MOD_LSHIFT = 2'd2;

    localparam logic [7:0] USAGE_NONE      = 8'd0;
    localparam logic [7:0] USAGE_LETTER_A  = 8'd4;
    localparam logic [7:0] USAGE_DIGIT_ONE = 8'd30;
    localparam logic [7:0] USAGE_DIGIT_0   = 8'd39;
    localparam logic [7:0] USAGE_ENTER     = 8'd40;
    localparam logic [7:0] USAGE_SPACE     = 8'd44;
    localparam logic [7:0] USAGE_COMMA     = 8'd54;
    localparam logic [7:0] USAGE_PERIOD    = 8'd55;

    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_ONE     = 8'h31;
    localparam logic [7:0] ASCII_NINE    = 8'h39;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_PERIOD  = 8'h2E;
    localparam logic [7:0] ASCII_COMMA   = 8'h2C;
    localparam logic [7:0] ASCII_NEWLINE = 8'h0A;
    localparam logic [7:0] ASCII_SPACE   = 8'h20;

    typedef logic [7:0] usage_t;

    typedef struct packed {
        usage_t code;
        logic   upper;
    } key_t;

    // Handed from one slot cell to the next.
    typedef struct packed {
        logic match;
        logic held;
    } slot_link_t;

    // Broadcast to every slot cell.
    typedef struct packed {
        usage_t code;
        logic   flush_pre;
        logic   flush_post;
        logic   accept;
    } slot_cmd_t;

    typedef struct packed {
        usage_t code_now;
        usage_t code_after;
        logic   used;
        logic   held_after;
    } slot_view_t;

    // One closed report; its release follows it on the output.
    typedef struct packed {
        logic                         shift;
        logic [KEY_SLOTS-1:0][7:0]    codes;
        logic                         last;
    } report_entry_t;

    typedef enum logic {
        BEAT_REPORT,
        BEAT_RELEASE
    } beat_t;

    function automatic key_t classify(input logic [7:0] c);
        key_t k;
        k.code  = USAGE_NONE;
        k.upper = 1'b0;
        priority if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z)
        begin
            k.code = 8'(c - ASCII_LOWER_A + USAGE_LETTER_A);
        end
        else if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z)
        begin
            k.code  = 8'(c - ASCII_UPPER_A + USAGE_LETTER_A);
            k.upper = 1'b1;
        end
        else if (c >= ASCII_ONE && c <= ASCII_NINE)
        begin
            k.code = 8'(c - ASCII_ONE + USAGE_DIGIT_ONE);
        end
        else if (c == ASCII_PERIOD)
        begin
            k.code = USAGE_PERIOD;
        end
        else if (c == ASCII_COMMA)
        begin
            k.code = USAGE_COMMA;
        end
        else if (c == ASCII_NEWLINE)
        begin
            k.code = USAGE_ENTER;
        end
        else if (c == ASCII_SPACE)
        begin
            k.code = USAGE_SPACE;
        end
        else if (c == ASCII_ZERO)
        begin
            k.code = USAGE_DIGIT_0;
        end
        else
        begin
            k.code = USAGE_NONE;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/a2hid_ifs.sv
// Channel interfaces of the report packer: characters in, keyboard reports out.
// Standalone; each carries valid, ready and the item payload.
`default_nettype none

interface a2hid_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, char_code, last_char, input ready);
    modport sink (input valid, char_code, last_char, output ready);
endinterface

interface a2hid_report_if;
    logic       valid;
    logic       ready;
    logic [1:0] modifier;
    logic       reserved_byte;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
    logic [7:0] key_slot_6;
    logic       end_of_run;

    modport source (
        output valid, modifier, reserved_byte, key_slot_1, key_slot_2, key_slot_3,
               key_slot_4, key_slot_5, key_slot_6, end_of_run,
        input  ready
    );
    modport sink (
        input  valid, modifier, reserved_byte, key_slot_1, key_slot_2, key_slot_3,
               key_slot_4, key_slot_5, key_slot_6, end_of_run,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/a2hid_slot_cell.sv
// One key slot of the open report: holds a usage code and its occupied flag.
// Depends on a2hid_pkg; cells are chained through slot_link_t.
`default_nettype none

module a2hid_slot_cell
    import a2hid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  slot_cmd_t  cmd,
    input  slot_link_t link_in,
    output slot_link_t link_out,
    output slot_view_t view
);

    logic   used_reg;
    logic   used_next;
    usage_t code_reg;
    logic   keep;
    logic   write;

    // A slot survives the character only if no early close empties the report.
    assign keep  = used_reg && !cmd.flush_pre;
    // The first free slot behind a kept one takes the new code.
    assign write = link_in.held && !keep;

    assign link_out.match = link_in.match || (used_reg && code_reg == cmd.code);
    assign link_out.held  = keep;

    assign view.code_now   = used_reg ? code_reg : USAGE_NONE;
    assign view.code_after = write ? cmd.code : (keep ? code_reg : USAGE_NONE);
    assign view.used       = used_reg;
    assign view.held_after = keep || write;

    always_comb
    begin
        used_next = used_reg;
        if (cmd.accept)
        begin
            used_next = (keep || write) && !cmd.flush_post;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && write)
        begin
            code_reg <= cmd.code;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/a2hid_report_queue.sv
// Queue of closed reports; each entry goes out as a report followed by its release.
// Depends on a2hid_pkg and a2hid_report_if.
`default_nettype none

module a2hid_report_queue
    import a2hid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_first,
    input  logic                  push_second,
    input  report_entry_t         entry_first,
    input  report_entry_t         entry_second,
    output logic                  room,
    a2hid_report_if.source        reports
);

    report_entry_t     entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    beat_t             beat_reg;
    beat_t             beat_next;
    logic [1:0]        push_n;
    logic              fire;
    logic              pop;
    report_entry_t     head;
    logic [7:0]        shown [REPORT_SLOTS];

    // An item may bring two entries, so two free places are needed to take one.
    assign room   = cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2);
    assign push_n = {1'b0, push_first} + {1'b0, push_first && push_second};
    assign fire   = reports.valid && reports.ready;
    assign pop    = fire && beat_reg == BEAT_RELEASE;
    assign head   = entries_reg[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
    assign cnt_next    = cnt_reg + QCNT_W'(push_n) - QCNT_W'(pop);

    always_comb
    begin
        beat_next = beat_reg;
        if (fire)
        begin
            unique case (beat_reg)
                BEAT_REPORT:  beat_next = BEAT_RELEASE;
                BEAT_RELEASE: beat_next = BEAT_REPORT;
                default:      beat_next = BEAT_REPORT;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < REPORT_SLOTS; i++)
        begin
            shown[i] = USAGE_NONE;
        end
        reports.valid         = cnt_reg != '0;
        reports.modifier      = MOD_NONE;
        reports.reserved_byte = 1'b0;
        reports.end_of_run    = 1'b0;
        unique case (beat_reg)
            BEAT_REPORT:
            begin
                reports.modifier = head.shift ? MOD_LSHIFT : MOD_NONE;
                for (int i = 0; i < KEY_SLOTS; i++)
                begin
                    shown[i] = head.codes[i];
                end
            end
            BEAT_RELEASE:
            begin
                reports.end_of_run = head.last;
            end
            default:
            begin
                reports.end_of_run = 1'b0;
            end
        endcase
        reports.key_slot_1 = shown[0];
        reports.key_slot_2 = shown[1];
        reports.key_slot_3 = shown[2];
        reports.key_slot_4 = shown[3];
        reports.key_slot_5 = shown[4];
        reports.key_slot_6 = shown[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            beat_reg   <= BEAT_REPORT;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            beat_reg   <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_first)
        begin
            entries_reg[wr_ptr_reg] <= entry_first;
        end
        if (push_first && push_second)
        begin
            entries_reg[QPTR_W'(wr_ptr_reg + 1'b1)] <= entry_second;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ascii_to_hid_keyboard_reports.sv
// Top level of the ASCII to HID keyboard report packer: a chain of slot cells and a report queue.
// Depends on a2hid_pkg, a2hid_ifs, a2hid_slot_cell and a2hid_report_queue.
//
//   Port     | Role          | Item
//   ---------+---------------+------------------------------------------------
//   chars    | input, sink   | one character and its end-of-string mark
//   reports  | output, source| one 8-byte keyboard report or release report
//
// A character is taken whenever the report queue has two free entries;
// it produces zero, two or four output items, one per cycle while reports.ready is high.
// The output side therefore sets the pace.
// Reset is asynchronous and empties the open report and the queue; there is no clearing pass.
// A stalled output keeps its item; characters keep flowing until the queue is short of room.
`default_nettype none

module ascii_to_hid_keyboard_reports
    import a2hid_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    a2hid_char_if.sink      chars,
    a2hid_report_if.source  reports
);

    logic          shift_reg;
    logic          shift_next;
    key_t          key;
    logic          accept;
    logic          room;
    logic          close_pre;
    logic          close_post;
    slot_cmd_t     cmd;
    slot_link_t    link [KEY_SLOTS+1];
    slot_view_t    view [KEY_SLOTS];
    report_entry_t entry_pre;
    report_entry_t entry_post;
    report_entry_t entry_first;

    assign key         = classify(chars.char_code);
    assign chars.ready = room;
    assign accept      = chars.valid && room;

    // The open report closes first if the case changes or a nonzero code would repeat.
    assign close_pre  = view[0].used
                     && ((key.upper != shift_reg)
                      || (key.code != USAGE_NONE && link[KEY_SLOTS].match));
    assign close_post = view[KEY_SLOTS-1].held_after || chars.last_char;

    assign cmd.code       = key.code;
    assign cmd.flush_pre  = close_pre;
    assign cmd.flush_post = close_post;
    assign cmd.accept     = accept;

    assign link[0].match = 1'b0;
    assign link[0].held  = 1'b1;

    for (genvar i = 0; i < KEY_SLOTS; i++)
    begin : g_slot
        a2hid_slot_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .view     (view[i])
        );
    end

    always_comb
    begin
        entry_pre.shift  = shift_reg;
        entry_pre.last   = !close_post;
        entry_post.shift = key.upper;
        entry_post.last  = 1'b1;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            entry_pre.codes[i]  = view[i].code_now;
            entry_post.codes[i] = view[i].code_after;
        end
        entry_first = close_pre ? entry_pre : entry_post;
    end

    assign shift_next = accept ? (key.upper && !close_post) : shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
        end
        else
        begin
            shift_reg <= shift_next;
        end
    end

    a2hid_report_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_first   (accept && (close_pre || close_post)),
        .push_second  (accept && close_pre && close_post),
        .entry_first  (entry_first),
        .entry_second (entry_post),
        .room         (room),
        .reports      (reports)
    );

endmodule

`default_nettype wire

### hw/rtl/a2hid_checker.sv
// Port-level checks for the report packer, attached to the top level by bind.
// Depends on a2hid_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module a2hid_checker
    import a2hid_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] modifier,
    input logic       reserved_byte,
    input logic [7:0] key_slot_1,
    input logic       end_of_run
);

    logic mod_known;
    logic blank_item;
    logic last_out;
    logic shift_fire;
    logic release_up;

    assign mod_known  = modifier == MOD_NONE || modifier == MOD_LSHIFT;
    // A release carries no modifier and an empty first slot.
    assign blank_item = modifier == MOD_NONE && key_slot_1 == USAGE_NONE;
    assign last_out   = out_valid && end_of_run;
    assign shift_fire = out_valid && out_ready && modifier == MOD_LSHIFT;
    assign release_up = out_valid && blank_item;

    `A2HID_ASSERT_ALWAYS(a_reserved_zero, !out_valid || !reserved_byte, "reserved byte set")
    `A2HID_ASSERT_ALWAYS(a_modifier_code, !out_valid || mod_known, "bad modifier")
    `A2HID_ASSERT_ALWAYS(a_end_is_release, !last_out || blank_item, "run ends on a report")
    `A2HID_ASSERT_NEXT(a_shift_then_release, shift_fire, release_up, "no release after shift")
    `A2HID_ASSERT_NEXT(a_valid_holds, out_valid && !out_ready, out_valid, "output item withdrawn")

endmodule

bind ascii_to_hid_keyboard_reports a2hid_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (reports.valid),
    .out_ready     (reports.ready),
    .modifier      (reports.modifier),
    .reserved_byte (reports.reserved_byte),
    .key_slot_1    (reports.key_slot_1),
    .end_of_run    (reports.end_of_run)
);

`default_nettype wire
